// File: hdl/bdu_pkg.sv
// Shared types, codes and constants for the button auto-repeat duty setter.
// No dependencies; used by bdu_core and button_autorepeat_duty_setter.
package bdu_pkg;

    localparam int DUTY_W  = 7;
    localparam int CMP_W   = 8;
    localparam int TICK_W  = 16;
    localparam int CFG_W   = 16;
    localparam int BTN_W   = 2;
    localparam int MASK_W  = 4;
    localparam int ACT_W   = 3;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 1;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    localparam logic [CFG_W-1:0] INITIAL_DELAY_RST   = 16'd700;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd50;

    // request opcodes
    localparam logic [OP_W-1:0] OP_PRESS = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_FAULT = 2'd2;

    // button codes
    localparam logic [BTN_W-1:0] BTN_A_UP   = 2'd0;
    localparam logic [BTN_W-1:0] BTN_A_DOWN = 2'd1;
    localparam logic [BTN_W-1:0] BTN_B_UP   = 2'd2;
    localparam logic [BTN_W-1:0] BTN_B_DOWN = 2'd3;

    localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LAST = 3'd4;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_INITIAL_DELAY   = 1'd0;
    localparam logic [IDX_W-1:0] REG_REPEAT_INTERVAL = 1'd1;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [BTN_W-1:0]  button;
        logic [MASK_W-1:0] held_mask;
    } req_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [CMP_W-1:0]  compare_a;
        logic [CMP_W-1:0]  compare_b;
        logic              halted;
        logic              repeat_active;
    } res_t;

    typedef struct packed {
        logic [CFG_W-1:0] initial_delay;
        logic [CFG_W-1:0] repeat_interval;
    } cfg_t;

    // Saturating up/down step of one setpoint.
    function automatic logic [DUTY_W-1:0] sat_step(input logic [DUTY_W-1:0] sp,
                                                   input logic             down);
        logic [DUTY_W-1:0] r;
        r = sp;
        if (down)
        begin
            if (sp != '0)
                r = sp - 1'b1;
        end
        else
        begin
            if (sp < DUTY_MAX)
                r = sp + 1'b1;
        end
        return r;
    endfunction

endpackage

// File: hdl/bdu_core.sv
// Setpoint, repeat counter and halt state with their update logic.
// Depends on bdu_pkg.
module bdu_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  bdu_pkg::req_t req,
    input  bdu_pkg::cfg_t cfg,
    output bdu_pkg::res_t res
);

    logic [bdu_pkg::DUTY_W-1:0] sp_a_reg, sp_a_next;
    logic [bdu_pkg::DUTY_W-1:0] sp_b_reg, sp_b_next;
    logic [bdu_pkg::ACT_W-1:0]  active_reg, active_next;
    logic [bdu_pkg::TICK_W-1:0] count_reg, count_next;
    logic [bdu_pkg::TICK_W-1:0] limit_reg, limit_next;
    logic                       counting_reg, counting_next;
    logic                       fault_reg, fault_next;

    logic [bdu_pkg::TICK_W-1:0] count_inc;
    logic [bdu_pkg::BTN_W-1:0]  act_btn;
    logic [bdu_pkg::BTN_W-1:0]  step_btn;
    logic                       step_en;

    assign count_inc = count_reg + 1'b1;
    assign act_btn   = bdu_pkg::BTN_W'(active_reg - 1'b1);

    always_comb
    begin
        active_next   = active_reg;
        count_next    = count_reg;
        limit_next    = limit_reg;
        counting_next = counting_reg;
        fault_next    = fault_reg;
        step_btn      = req.button;
        step_en       = 1'b0;

        if (fire && !fault_reg)
        begin
            case (req.opcode)
                bdu_pkg::OP_PRESS:
                begin
                    step_en       = 1'b1;
                    active_next   = {1'b0, req.button} + 1'b1;
                    count_next    = '0;
                    limit_next    = cfg.initial_delay;
                    counting_next = 1'b1;
                end
                bdu_pkg::OP_TICK:
                begin
                    if (counting_reg)
                    begin
                        count_next = count_inc;
                        if (count_inc > limit_reg)
                        begin
                            if (active_reg != bdu_pkg::ACT_NONE
                                && active_reg <= bdu_pkg::ACT_LAST)
                            begin
                                step_btn = act_btn;
                                step_en  = req.held_mask[act_btn];
                            end
                            else
                            begin
                                counting_next = 1'b0;
                                active_next   = bdu_pkg::ACT_NONE;
                            end
                            limit_next = cfg.repeat_interval;
                            count_next = '0;
                        end
                        // all buttons released: stop repeating
                        if (req.held_mask == '0)
                        begin
                            counting_next = 1'b0;
                            count_next    = '0;
                        end
                    end
                end
                bdu_pkg::OP_FAULT:
                begin
                    fault_next    = 1'b1;
                    counting_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        sp_a_next = sp_a_reg;
        sp_b_next = sp_b_reg;
        if (step_en)
        begin
            case (step_btn)
                bdu_pkg::BTN_A_UP:   sp_a_next = bdu_pkg::sat_step(sp_a_reg, 1'b0);
                bdu_pkg::BTN_A_DOWN: sp_a_next = bdu_pkg::sat_step(sp_a_reg, 1'b1);
                bdu_pkg::BTN_B_UP:   sp_b_next = bdu_pkg::sat_step(sp_b_reg, 1'b0);
                default:             sp_b_next = bdu_pkg::sat_step(sp_b_reg, 1'b1);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_a_reg     <= '0;
            sp_b_reg     <= '0;
            active_reg   <= bdu_pkg::ACT_NONE;
            count_reg    <= '0;
            limit_reg    <= '0;
            counting_reg <= 1'b0;
            fault_reg    <= 1'b0;
        end
        else
        begin
            sp_a_reg     <= sp_a_next;
            sp_b_reg     <= sp_b_next;
            active_reg   <= active_next;
            count_reg    <= count_next;
            limit_reg    <= limit_next;
            counting_reg <= counting_next;
            fault_reg    <= fault_next;
        end
    end

    // result reflects the state after this request
    always_comb
    begin
        res.duty_a        = sp_a_next;
        res.duty_b        = sp_b_next;
        res.compare_a     = fault_next ? '0 : {sp_a_next, 1'b0};
        res.compare_b     = fault_next ? '0 : {sp_b_next, 1'b0};
        res.halted        = fault_next;
        res.repeat_active = counting_next;
    end

endmodule

// File: hdl/button_autorepeat_duty_setter.sv
// Top level of the button auto-repeat duty setter: request and result registers,
// configuration registers. Depends on bdu_pkg and bdu_core.
//
// Usage:
//   Requests (press edge, millisecond tick, fault) enter on req_valid/req_stall/
//   req_data; one result per request leaves on res_valid/res_stall/res_data,
//   holding both duty setpoints, their PWM compare values, halt and repeat status.
//   A request is taken when valid is high and stall is low.
//   A request passes the request register, then the result register, before its
//   result is valid; a stalled receiver can hold it in the request register.
//   Throughput: one request per cycle while the receiver does not stall;
//   the whole update is one pass of logic between the two registers.
//   When the receiver stalls, the result register holds; the request register
//   still takes one more request, then req_stall rises until the result drains.
//   Configuration (initial_delay, repeat_interval) is written through cfg_wr_en,
//   cfg_index and cfg_data; the user must do so while no request is in flight (not enforced).
//   Reset clears both setpoints, the repeat counter and the halt, and loads the
//   configuration registers with 700 and 50 ticks.
//   After a fault request the block ignores every later press and tick.
module button_autorepeat_duty_setter
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  bdu_pkg::req_t               req_data,
    output logic                        res_valid,
    input  logic                        res_stall,
    output bdu_pkg::res_t               res_data,
    input  logic                        cfg_wr_en,
    input  logic [bdu_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bdu_pkg::CFG_W-1:0]   cfg_data
);

    bdu_pkg::cfg_t cfg_reg;
    bdu_pkg::req_t req_reg;
    bdu_pkg::res_t res_reg;
    bdu_pkg::res_t core_res;
    logic          req_vld_reg;
    logic          res_vld_reg;
    logic          advance;
    logic          req_take;

    assign advance   = req_vld_reg && (!res_vld_reg || !res_stall);
    assign req_stall = req_vld_reg && !advance;
    assign req_take  = req_valid && !req_stall;
    assign res_valid = res_vld_reg;
    assign res_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_delay   <= bdu_pkg::INITIAL_DELAY_RST;
            cfg_reg.repeat_interval <= bdu_pkg::REPEAT_INTERVAL_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bdu_pkg::REG_INITIAL_DELAY:   cfg_reg.initial_delay   <= cfg_data;
                bdu_pkg::REG_REPEAT_INTERVAL: cfg_reg.repeat_interval <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (req_take)
                req_vld_reg <= 1'b1;
            else if (advance)
                req_vld_reg <= 1'b0;

            if (advance)
                res_vld_reg <= 1'b1;
            else if (!res_stall)
                res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            req_reg <= req_data;
        if (advance)
            res_reg <= core_res;
    end

    bdu_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (req_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    // a halt also stops the repeat counter
    a_halt_stops_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.halted |-> !res_reg.repeat_active)
        else $error("repeat active while halted");

    // the halt never clears once latched
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.halted |=> res_reg.halted)
        else $error("halt released");

    // setpoints saturate at the top of the range
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> (res_reg.duty_a <= bdu_pkg::DUTY_MAX
                         && res_reg.duty_b <= bdu_pkg::DUTY_MAX))
        else $error("duty above maximum");

    // compare values follow the setpoints while running
    a_compare_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && !res_reg.halted |->
            (res_reg.compare_a == {res_reg.duty_a, 1'b0}
             && res_reg.compare_b == {res_reg.duty_b, 1'b0}))
        else $error("compare value does not match duty");

endmodule
